// ----- src/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg: session controller shared types and codes
// Event and state codes, header constants, status bytes and the item types
// used by the command session controller.
// ----------------------------------------------------------------------------
package asc_pkg;

	// event codes
	localparam logic [2:0] ACT_TICK     = 3'd0;
	localparam logic [2:0] ACT_ACTIVATE = 3'd1;
	localparam logic [2:0] ACT_COMMAND  = 3'd2;
	localparam logic [2:0] ACT_RX_TMO   = 3'd3;
	localparam logic [2:0] ACT_FRM_ERR  = 3'd4;
	localparam logic [2:0] ACT_RELEASE  = 3'd5;

	// activation outcomes
	localparam logic [1:0] ACTV_OK  = 2'd0;
	localparam logic [1:0] ACTV_TMO = 2'd1;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ACT_TMO  = 2'd1;
	localparam logic [1:0] ERR_ACT_FAIL = 2'd2;

	// session states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACT  = 2'd1;
	localparam logic [1:0] ST_HS   = 2'd2;
	localparam logic [1:0] ST_SEC  = 2'd3;

	// header
	localparam logic [8:0] HDR_LEN    = 9'd5;
	localparam logic [7:0] CLA_PROP   = 8'h80;
	localparam logic [7:0] INS_HS_INIT = 8'h10;
	localparam logic [7:0] INS_HS_FIN  = 8'h11;
	localparam logic [7:0] INS_PAYLOAD = 8'h20;
	localparam logic [7:0] INS_ABORT   = 8'h30;

	// status bytes
	localparam logic [7:0] SW1_OK      = 8'h90;
	localparam logic [7:0] SW1_CMD_NA  = 8'h69;
	localparam logic [7:0] SW1_BAD_PRM = 8'h6A;
	localparam logic [7:0] SW2_NONE    = 8'h00;
	localparam logic [7:0] SW2_BAD_LEN = 8'h80;
	localparam logic [7:0] SW2_BAD_CLA = 8'h81;
	localparam logic [7:0] SW2_SEC_NS  = 8'h82;
	localparam logic [7:0] SW2_COND_NS = 8'h85;

	// configuration registers
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HS_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAY_LIMIT  = 1'b1;
	localparam logic [15:0] HS_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  PAY_LIMIT_RST  = 8'd227;

	typedef struct packed {
		logic [15:0] hs_timeout;
		logic [7:0]  pay_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] activation_code;
		logic [8:0] frame_length;
		logic [7:0] class_byte;
		logic [7:0] instruction;
		logic [7:0] data_length;
		logic       app_accepts;
		logic       reply_sent;
	} in_item_t;

	typedef struct packed {
		logic       status_valid;
		logic [7:0] status_first;
		logic [7:0] status_second;
		logic       forward_to_app;
		logic       send_reply;
		logic       erase_keys;
		logic       link_abort;
		logic [1:0] session_state;
		logic [1:0] error_code;
	} out_item_t;

endpackage

// ----- src/asc_if.sv -----
// ----------------------------------------------------------------------------
// asc_if: session controller channels
// Event channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface asc_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [1:0] activation_code;
	logic [8:0] frame_length;
	logic [7:0] class_byte;
	logic [7:0] instruction;
	logic [7:0] data_length;
	logic       app_accepts;
	logic       reply_sent;

	modport source (
		output valid, action, activation_code, frame_length, class_byte,
		       instruction, data_length, app_accepts, reply_sent,
		input  ready
	);
	modport sink (
		input  valid, action, activation_code, frame_length, class_byte,
		       instruction, data_length, app_accepts, reply_sent,
		output ready
	);
endinterface

interface asc_out_if;
	logic       valid;
	logic       ready;
	logic       status_valid;
	logic [7:0] status_first;
	logic [7:0] status_second;
	logic       forward_to_app;
	logic       send_reply;
	logic       erase_keys;
	logic       link_abort;
	logic [1:0] session_state;
	logic [1:0] error_code;

	modport source (
		output valid, status_valid, status_first, status_second, forward_to_app,
		       send_reply, erase_keys, link_abort, session_state, error_code,
		input  ready
	);
	modport sink (
		input  valid, status_valid, status_first, status_second, forward_to_app,
		       send_reply, erase_keys, link_abort, session_state, error_code,
		output ready
	);
endinterface

// ----- src/asc_cfg.sv -----
// ----------------------------------------------------------------------------
// asc_cfg: configuration registers
// Handshake timeout and payload limit, written through a plain write port.
// ----------------------------------------------------------------------------
module asc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [asc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [asc_pkg::CFG_DATA_W-1:0]     wr_data,
	output asc_pkg::cfg_t                      cfg
);
	logic [15:0] hs_timeout_q;
	logic [7:0]  pay_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_timeout_q <= asc_pkg::HS_TIMEOUT_RST;
			pay_limit_q  <= asc_pkg::PAY_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				asc_pkg::REG_HS_TIMEOUT: hs_timeout_q <= wr_data[15:0];
				asc_pkg::REG_PAY_LIMIT:  pay_limit_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.hs_timeout = hs_timeout_q;
	assign cfg.pay_limit  = pay_limit_q;
endmodule

// ----- src/asc_step.sv -----
// ----------------------------------------------------------------------------
// asc_step: session state and event evaluation
// Holds the session state and handshake tick count, evaluates one event
// against them and commits the new state when the event advances.
// ----------------------------------------------------------------------------
module asc_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  asc_pkg::in_item_t    item,
	input  asc_pkg::cfg_t        cfg,
	output asc_pkg::out_item_t   res
);
	logic [1:0]  state_q;
	logic [15:0] remaining_q;
	logic [1:0]  state_d;
	logic [15:0] remaining_d;
	logic [7:0]  want_ins;
	logic        len_match;

	assign len_match = ({1'b0, item.data_length} == (item.frame_length - asc_pkg::HDR_LEN));

	always_comb begin
		case (state_q)
			asc_pkg::ST_ACT: want_ins = asc_pkg::INS_HS_INIT;
			asc_pkg::ST_HS:  want_ins = asc_pkg::INS_HS_FIN;
			default:         want_ins = asc_pkg::INS_PAYLOAD;
		endcase
	end

	always_comb begin
		res               = '0;
		res.error_code    = asc_pkg::ERR_NONE;
		state_d           = state_q;
		remaining_d       = remaining_q;
		case (item.action)
			asc_pkg::ACT_TICK: begin
				if (state_q == asc_pkg::ST_HS) begin
					if (remaining_q <= 16'd1) begin
						res.erase_keys = 1'b1;
						res.link_abort = 1'b1;
						state_d        = asc_pkg::ST_IDLE;
						remaining_d    = '0;
					end else begin
						remaining_d = remaining_q - 16'd1;
					end
				end
			end
			asc_pkg::ACT_ACTIVATE: begin
				if (state_q == asc_pkg::ST_IDLE) begin
					if (item.activation_code == asc_pkg::ACTV_OK)
						state_d = asc_pkg::ST_ACT;
					else if (item.activation_code == asc_pkg::ACTV_TMO)
						res.error_code = asc_pkg::ERR_ACT_TMO;
					else
						res.error_code = asc_pkg::ERR_ACT_FAIL;
				end
			end
			asc_pkg::ACT_COMMAND: begin
				if (state_q == asc_pkg::ST_IDLE) begin
					state_d = state_q;
				end else if (item.frame_length < asc_pkg::HDR_LEN) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_BAD_PRM;
					res.status_second = asc_pkg::SW2_BAD_LEN;
				end else if (item.class_byte != asc_pkg::CLA_PROP) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_BAD_PRM;
					res.status_second = asc_pkg::SW2_BAD_CLA;
				end else if (!len_match) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_BAD_PRM;
					res.status_second = asc_pkg::SW2_BAD_LEN;
				end else if (item.instruction == asc_pkg::INS_ABORT) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_OK;
					res.status_second = asc_pkg::SW2_NONE;
					res.erase_keys    = 1'b1;
					res.link_abort    = 1'b1;
					state_d           = asc_pkg::ST_IDLE;
					remaining_d       = '0;
				end else if (item.instruction != want_ins) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_CMD_NA;
					res.status_second = asc_pkg::SW2_COND_NS;
				end else if (state_q == asc_pkg::ST_SEC
				             && item.data_length > cfg.pay_limit) begin
					res.status_valid  = 1'b1;
					res.status_first  = asc_pkg::SW1_BAD_PRM;
					res.status_second = asc_pkg::SW2_BAD_LEN;
				end else begin
					res.forward_to_app = 1'b1;
					if (!item.app_accepts) begin
						res.status_valid  = 1'b1;
						res.status_first  = asc_pkg::SW1_CMD_NA;
						res.status_second = asc_pkg::SW2_SEC_NS;
						res.erase_keys    = 1'b1;
						res.link_abort    = 1'b1;
						state_d           = asc_pkg::ST_IDLE;
						remaining_d       = '0;
					end else if (state_q == asc_pkg::ST_HS) begin
						res.status_valid  = 1'b1;
						res.status_first  = asc_pkg::SW1_OK;
						res.status_second = asc_pkg::SW2_NONE;
						state_d           = asc_pkg::ST_SEC;
						remaining_d       = '0;
					end else if (!item.reply_sent) begin
						res.erase_keys = 1'b1;
						res.link_abort = 1'b1;
						state_d        = asc_pkg::ST_IDLE;
						remaining_d    = '0;
					end else begin
						res.send_reply = 1'b1;
						if (state_q == asc_pkg::ST_ACT) begin
							state_d     = asc_pkg::ST_HS;
							remaining_d = cfg.hs_timeout;
						end
					end
				end
			end
			asc_pkg::ACT_RX_TMO, asc_pkg::ACT_RELEASE: begin
				if (state_q != asc_pkg::ST_IDLE) begin
					res.erase_keys = 1'b1;
					res.link_abort = 1'b1;
					state_d        = asc_pkg::ST_IDLE;
					remaining_d    = '0;
				end
			end
			asc_pkg::ACT_FRM_ERR: begin
				if (state_q == asc_pkg::ST_ACT || state_q == asc_pkg::ST_SEC) begin
					res.erase_keys = 1'b1;
					res.link_abort = 1'b1;
					state_d        = asc_pkg::ST_IDLE;
					remaining_d    = '0;
				end
			end
			default: ;
		endcase
		res.session_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asc_pkg::ST_IDLE;
			remaining_q <= '0;
		end else if (en) begin
			state_q     <= state_d;
			remaining_q <= remaining_d;
		end
	end

	a_abort_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.link_abort |=> state_q == asc_pkg::ST_IDLE)
		else $error("abort did not return the session to idle");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(state_q) && $stable(remaining_q))
		else $error("session state changed without an event");

	a_count_only_in_hs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != asc_pkg::ST_HS |-> remaining_q == 16'd0)
		else $error("tick count held outside handshake");

	a_no_forward_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.forward_to_app |-> state_q != asc_pkg::ST_IDLE)
		else $error("command forwarded with no link up");
endmodule

// ----- src/apdu_session_controller.sv -----
// ----------------------------------------------------------------------------
// apdu_session_controller: command session sequencer
// Registers each event, evaluates it against the session state and presents
// one result item per event.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while the result channel does not stall,
// and each gives exactly one result. The rate is set by the session state
// update, which evaluates and commits one event between the event register and
// the result register; the result register lets the next event in while a
// finished result waits on the result channel.
module apdu_session_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	asc_in_if.sink                          in_ch,
	asc_out_if.source                       out_ch,
	input  logic                            wr_en,
	input  logic [asc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [asc_pkg::CFG_DATA_W-1:0]  wr_data
);
	asc_pkg::cfg_t      cfg;
	asc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	asc_pkg::out_item_t res;
	asc_pkg::out_item_t res_s2;
	logic               valid_s2;
	logic               adv;
	logic               in_xfer;

	assign adv          = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign in_xfer      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ch.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.action          <= in_ch.action;
			item_s1.activation_code <= in_ch.activation_code;
			item_s1.frame_length    <= in_ch.frame_length;
			item_s1.class_byte      <= in_ch.class_byte;
			item_s1.instruction     <= in_ch.instruction;
			item_s1.data_length     <= in_ch.data_length;
			item_s1.app_accepts     <= in_ch.app_accepts;
			item_s1.reply_sent      <= in_ch.reply_sent;
		end
		if (adv)
			res_s2 <= res;
	end

	asc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	asc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_ch.valid          = valid_s2;
	assign out_ch.status_valid   = res_s2.status_valid;
	assign out_ch.status_first   = res_s2.status_first;
	assign out_ch.status_second  = res_s2.status_second;
	assign out_ch.forward_to_app = res_s2.forward_to_app;
	assign out_ch.send_reply     = res_s2.send_reply;
	assign out_ch.erase_keys     = res_s2.erase_keys;
	assign out_ch.link_abort     = res_s2.link_abort;
	assign out_ch.session_state  = res_s2.session_state;
	assign out_ch.error_code     = res_s2.error_code;
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: command session controller testbench
// Feeds session events through the event channel and checks every result
// against a cycle-free prediction of the session state machine. A directed
// walk through each state comes first. Randomized sessions follow under four
// register settings, with idle bursts on both channels in all but the last, a long result stall
// and a full drain between settings.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] ACTV_FAIL   = 2'd2;
	localparam logic [1:0] ACTV_OTHER  = 2'd3;
	localparam logic [2:0] ACT_RSVD_LO = 3'd6;
	localparam logic [2:0] ACT_RSVD_HI = 3'd7;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 3000;

	logic clk;
	logic arst_n = 1'b0;

	logic                           wr_en    = 1'b0;
	logic [asc_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [asc_pkg::CFG_DATA_W-1:0] wr_data  = '0;

	logic               src_valid = 1'b0;
	asc_pkg::in_item_t  src_item  = '0;
	logic               snk_ready = 1'b0;
	int                 src_gap   = 0;
	int                 snk_gap   = 0;
	int                 hold_left = 0;
	int                 hold_reqs = 0;
	int                 hold_served = 0;
	logic               idle_en   = 1'b1;
	int                 idle_cycles = 0;

	// predicted session state and register copies
	logic [1:0]  sess    = asc_pkg::ST_IDLE;
	logic [15:0] hs_left = '0;
	logic [15:0] cfg_hs_timeout = asc_pkg::HS_TIMEOUT_RST;
	logic [7:0]  cfg_pay_limit  = asc_pkg::PAY_LIMIT_RST;

	asc_pkg::in_item_t  event_q[$];
	asc_pkg::out_item_t verdict_q[$];
	asc_pkg::out_item_t oldest;

	int n_queued = 0;
	int n_events = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_secure = 0;
	int n_expired = 0;

	asc_in_if  in_ch ();
	asc_out_if out_ch ();

	assign in_ch.valid           = src_valid;
	assign in_ch.action          = src_item.action;
	assign in_ch.activation_code = src_item.activation_code;
	assign in_ch.frame_length    = src_item.frame_length;
	assign in_ch.class_byte      = src_item.class_byte;
	assign in_ch.instruction     = src_item.instruction;
	assign in_ch.data_length     = src_item.data_length;
	assign in_ch.app_accepts     = src_item.app_accepts;
	assign in_ch.reply_sent      = src_item.reply_sent;
	assign out_ch.ready          = snk_ready;

	apdu_session_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void put_sw(inout asc_pkg::out_item_t r, input logic [7:0] a,
		input logic [7:0] b);
		r.status_valid  = 1'b1;
		r.status_first  = a;
		r.status_second = b;
	endfunction

	function automatic void end_link(inout asc_pkg::out_item_t r);
		r.erase_keys = 1'b1;
		r.link_abort = 1'b1;
		sess = asc_pkg::ST_IDLE;
		hs_left = '0;
	endfunction

	function automatic asc_pkg::out_item_t session_step(input asc_pkg::in_item_t ev);
		asc_pkg::out_item_t r;
		logic [7:0]         want_ins;
		r = '0;
		case (ev.action)
			asc_pkg::ACT_TICK: if (sess == asc_pkg::ST_HS) begin
				if (hs_left <= 16'd1) begin
					end_link(r);
					n_expired++;
				end else begin
					hs_left = hs_left - 16'd1;
				end
			end
			asc_pkg::ACT_ACTIVATE: if (sess == asc_pkg::ST_IDLE) begin
				if (ev.activation_code == asc_pkg::ACTV_OK)
					sess = asc_pkg::ST_ACT;
				else if (ev.activation_code == asc_pkg::ACTV_TMO)
					r.error_code = asc_pkg::ERR_ACT_TMO;
				else
					r.error_code = asc_pkg::ERR_ACT_FAIL;
			end
			asc_pkg::ACT_COMMAND: if (sess != asc_pkg::ST_IDLE) begin
				case (sess)
					asc_pkg::ST_ACT: want_ins = asc_pkg::INS_HS_INIT;
					asc_pkg::ST_HS: want_ins = asc_pkg::INS_HS_FIN;
					default: want_ins = asc_pkg::INS_PAYLOAD;
				endcase
				if (ev.frame_length < asc_pkg::HDR_LEN) begin
					put_sw(r, asc_pkg::SW1_BAD_PRM, asc_pkg::SW2_BAD_LEN);
				end else if (ev.class_byte != asc_pkg::CLA_PROP) begin
					put_sw(r, asc_pkg::SW1_BAD_PRM, asc_pkg::SW2_BAD_CLA);
				end else if ({1'b0, ev.data_length} != ev.frame_length - asc_pkg::HDR_LEN) begin
					put_sw(r, asc_pkg::SW1_BAD_PRM, asc_pkg::SW2_BAD_LEN);
				end else if (ev.instruction == asc_pkg::INS_ABORT) begin
					put_sw(r, asc_pkg::SW1_OK, asc_pkg::SW2_NONE);
					end_link(r);
				end else if (ev.instruction != want_ins) begin
					put_sw(r, asc_pkg::SW1_CMD_NA, asc_pkg::SW2_COND_NS);
				end else if (sess == asc_pkg::ST_SEC && ev.data_length > cfg_pay_limit) begin
					put_sw(r, asc_pkg::SW1_BAD_PRM, asc_pkg::SW2_BAD_LEN);
				end else begin
					r.forward_to_app = 1'b1;
					if (!ev.app_accepts) begin
						put_sw(r, asc_pkg::SW1_CMD_NA, asc_pkg::SW2_SEC_NS);
						end_link(r);
					end else if (sess == asc_pkg::ST_HS) begin
						put_sw(r, asc_pkg::SW1_OK, asc_pkg::SW2_NONE);
						sess = asc_pkg::ST_SEC;
						hs_left = '0;
						n_secure++;
					end else if (!ev.reply_sent) begin
						end_link(r);
					end else begin
						r.send_reply = 1'b1;
						if (sess == asc_pkg::ST_ACT) begin
							sess = asc_pkg::ST_HS;
							hs_left = cfg_hs_timeout;
						end
					end
				end
			end
			asc_pkg::ACT_RX_TMO, asc_pkg::ACT_RELEASE: if (sess != asc_pkg::ST_IDLE) begin
				end_link(r);
			end
			asc_pkg::ACT_FRM_ERR: if (sess == asc_pkg::ST_ACT || sess == asc_pkg::ST_SEC) begin
				end_link(r);
			end
			default: ;
		endcase
		r.session_state = sess;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap <= 0;
			sess = asc_pkg::ST_IDLE;
			hs_left = '0;
		end else begin
			if (src_valid && in_ch.ready) begin
				verdict_q.push_back(session_step(src_item));
				n_events++;
			end
			if (!src_valid || in_ch.ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					src_valid <= 1'b0;
				end else if (event_q.size() != 0) begin
					src_item <= event_q.pop_front();
					src_valid <= 1'b1;
					if (idle_en && $urandom_range(0, 5) == 0)
						src_gap <= $urandom_range(1, 19);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	task automatic cmp(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			n_mismatch++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snk_ready <= 1'b0;
			snk_gap <= 0;
			hold_left <= 0;
		end else begin
			if (out_ch.valid && snk_ready) begin
				if (verdict_q.size() == 0) begin
					$error("result transfer with no event awaiting it");
					n_mismatch++;
				end else begin
					oldest = verdict_q.pop_front();
					cmp("status_valid", 8'(oldest.status_valid), 8'(out_ch.status_valid));
					cmp("status_first", oldest.status_first, out_ch.status_first);
					cmp("status_second", oldest.status_second, out_ch.status_second);
					cmp("forward_to_app", 8'(oldest.forward_to_app), 8'(out_ch.forward_to_app));
					cmp("send_reply", 8'(oldest.send_reply), 8'(out_ch.send_reply));
					cmp("erase_keys", 8'(oldest.erase_keys), 8'(out_ch.erase_keys));
					cmp("link_abort", 8'(oldest.link_abort), 8'(out_ch.link_abort));
					cmp("session_state", 8'(oldest.session_state), 8'(out_ch.session_state));
					cmp("error_code", 8'(oldest.error_code), 8'(out_ch.error_code));
					n_checked++;
				end
			end
			if (hold_served != hold_reqs) begin
				hold_served <= hold_reqs;
				hold_left <= LONG_HOLD;
				snk_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				snk_ready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap <= snk_gap - 1;
				snk_ready <= 1'b0;
			end else begin
				snk_ready <= 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0)
					snk_gap <= $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && in_ch.ready) || (out_ch.valid && snk_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void offer(input asc_pkg::in_item_t e);
		event_q.push_back(e);
		n_queued++;
	endfunction

	function automatic asc_pkg::in_item_t rand_event(input logic [2:0] act);
		asc_pkg::in_item_t e;
		e.action          = act;
		e.activation_code = 2'($urandom_range(0, 3));
		e.frame_length    = 9'($urandom_range(0, 264));
		e.class_byte      = 8'($urandom_range(0, 255));
		e.instruction     = 8'($urandom_range(0, 255));
		e.data_length     = 8'($urandom_range(0, 255));
		e.app_accepts     = 1'($urandom_range(0, 1));
		e.reply_sent      = 1'($urandom_range(0, 1));
		return e;
	endfunction

	function automatic asc_pkg::in_item_t command(input logic [7:0] ins, input logic [7:0] lc);
		asc_pkg::in_item_t e;
		e = rand_event(asc_pkg::ACT_COMMAND);
		e.class_byte   = asc_pkg::CLA_PROP;
		e.instruction  = ins;
		e.data_length  = lc;
		e.frame_length = {1'b0, lc} + asc_pkg::HDR_LEN;
		e.app_accepts  = 1'b1;
		e.reply_sent   = 1'b1;
		return e;
	endfunction

	function automatic asc_pkg::in_item_t roughen(input asc_pkg::in_item_t e);
		if ($urandom_range(0, 5) != 0)
			return e;
		case ($urandom_range(0, 6))
			0: e.frame_length = 9'($urandom_range(0, 4));
			1: e.class_byte = e.class_byte ^ 8'($urandom_range(1, 255));
			2: e.data_length = e.data_length ^ 8'($urandom_range(1, 255));
			3: e.instruction = 8'($urandom_range(0, 255));
			4: e.app_accepts = 1'b0;
			5: e.reply_sent = 1'b0;
			default: e.instruction = asc_pkg::INS_ABORT;
		endcase
		return e;
	endfunction

	function automatic void play_session();
		asc_pkg::in_item_t e;
		logic [7:0]        lc;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 4))
				offer(rand_event(3'($urandom_range(0, 7))));
		e = rand_event(asc_pkg::ACT_ACTIVATE);
		e.activation_code = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3))
			: asc_pkg::ACTV_OK;
		offer(e);
		offer(roughen(command(asc_pkg::INS_HS_INIT, 8'($urandom_range(0, 255)))));
		repeat ($urandom_range(0, 4))
			offer(rand_event(($urandom_range(0, 5) == 0) ? asc_pkg::ACT_FRM_ERR
				: asc_pkg::ACT_TICK));
		offer(roughen(command(asc_pkg::INS_HS_FIN, 8'($urandom_range(0, 255)))));
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 7) == 0)
				offer(rand_event(asc_pkg::ACT_TICK));
			lc = $urandom_range(0, 1) ? 8'($urandom_range(0, cfg_pay_limit))
				: 8'($urandom_range(0, 255));
			offer(roughen(command(asc_pkg::INS_PAYLOAD, lc)));
		end
		case ($urandom_range(0, 4))
			0: offer(rand_event(asc_pkg::ACT_RELEASE));
			1: offer(rand_event(asc_pkg::ACT_RX_TMO));
			2: offer(rand_event(asc_pkg::ACT_FRM_ERR));
			3: offer(command(asc_pkg::INS_ABORT, 8'($urandom_range(0, 255))));
			default: ;
		endcase
	endfunction

	task automatic fill(input int n);
		int stop;
		stop = n_queued + n;
		while (n_queued < stop)
			play_session();
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (event_q.size() != 0 || src_valid || verdict_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [asc_pkg::CFG_IDX_W-1:0] idx,
		input logic [asc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == asc_pkg::REG_HS_TIMEOUT)
			cfg_hs_timeout = val;
		else
			cfg_pay_limit = val[7:0];
	endtask

	task automatic set_config(input logic [15:0] hs, input logic [15:0] pl);
		write_reg(asc_pkg::REG_HS_TIMEOUT, hs);
		write_reg(asc_pkg::REG_PAY_LIMIT, pl);
		@(negedge clk);
	endtask

	initial begin
		asc_pkg::in_item_t e;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk every state at the reset settings
		offer(rand_event(asc_pkg::ACT_COMMAND));
		offer(rand_event(asc_pkg::ACT_TICK));
		offer(rand_event(asc_pkg::ACT_RELEASE));
		e = rand_event(asc_pkg::ACT_ACTIVATE);
		e.activation_code = asc_pkg::ACTV_TMO;
		offer(e);
		e.activation_code = ACTV_FAIL;
		offer(e);
		e.activation_code = ACTV_OTHER;
		offer(e);
		e.activation_code = asc_pkg::ACTV_OK;
		offer(e);
		offer(e);
		e = command(asc_pkg::INS_HS_INIT, 8'd0);
		e.frame_length = 9'd4;
		offer(e);
		e = command(asc_pkg::INS_HS_INIT, 8'd0);
		e.class_byte = 8'h00;
		offer(e);
		e = command(asc_pkg::INS_HS_INIT, 8'd7);
		e.data_length = 8'd6;
		offer(e);
		offer(command(asc_pkg::INS_PAYLOAD, 8'd0));
		offer(rand_event(asc_pkg::ACT_FRM_ERR));
		e = rand_event(asc_pkg::ACT_ACTIVATE);
		e.activation_code = asc_pkg::ACTV_OK;
		offer(e);
		offer(command(asc_pkg::INS_HS_INIT, 8'd255));
		offer(rand_event(asc_pkg::ACT_FRM_ERR));
		offer(rand_event(asc_pkg::ACT_TICK));
		e = command(asc_pkg::INS_HS_FIN, 8'd0);
		e.frame_length = 9'd0;
		offer(e);
		e = command(asc_pkg::INS_HS_FIN, 8'd3);
		e.reply_sent = 1'b0;
		offer(e);
		offer(command(asc_pkg::INS_PAYLOAD, 8'd255));
		offer(command(asc_pkg::INS_PAYLOAD, 8'd227));
		e = command(asc_pkg::INS_PAYLOAD, 8'd1);
		e.reply_sent = 1'b0;
		offer(e);
		offer(rand_event(ACT_RSVD_LO));
		offer(rand_event(ACT_RSVD_HI));
		fill(120);
		drain();

		// shortest handshake, no payload allowed; stall results for a long stretch
		set_config(16'd1, {8'($urandom_range(0, 255)), 8'd0});
		hold_reqs = hold_reqs + 1;
		fill(130);
		drain();

		// longest handshake, widest payload; pause mid-way until all results are in
		set_config(16'hFFFF, {8'($urandom_range(0, 255)), 8'd255});
		fill(65);
		drain();
		fill(65);
		drain();

		// short handshake that expires after a few ticks, no idling
		set_config(16'($urandom_range(2, 6)), 16'($urandom_range(0, 65535)));
		idle_en = 1'b0;
		fill(150);
		drain();

		repeat (8) @(posedge clk);
		$display("%0d events sent, %0d results checked over four register settings",
			n_events, n_checked);
		$display("%0d handshakes completed, %0d handshake expiries", n_secure, n_expired);
		if (n_mismatch == 0 && verdict_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
